### rtl/kli_pkg.sv
package kli_pkg;

    localparam int MAX_KEYS  = 16;
    localparam int FRAC_BITS = 16;
    localparam int KEY_IDX_W = $clog2(MAX_KEYS);
    localparam int TIME_W    = 32;
    localparam int VAL_W     = 32;
    localparam int COUNT_W   = 5;
    localparam int SLOT_W    = 4;
    localparam int SEG_W     = 4;
    localparam int DIV_CNT_W = $clog2(FRAC_BITS);
    localparam int DIFF_W    = VAL_W + 1;
    localparam int PROD_W    = DIFF_W + FRAC_BITS + 1;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_SINGLE  = 2'd1,
        ST_PAST    = 2'd2,
        ST_CLAMPED = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_LOAD_A,
        S_DIV,
        S_DIFF,
        S_MUL,
        S_ADD,
        S_OUT
    } fsm_t;

    typedef struct packed {
        logic                     opcode;
        logic [SLOT_W-1:0]        key_index;
        logic [TIME_W-1:0]        key_time;
        logic signed [VAL_W-1:0]  value_x;
        logic signed [VAL_W-1:0]  value_y;
        logic signed [VAL_W-1:0]  value_z;
        logic [TIME_W-1:0]        query_time;
    } req_word_t;

    typedef struct packed {
        logic signed [VAL_W-1:0]  out_x;
        logic signed [VAL_W-1:0]  out_y;
        logic signed [VAL_W-1:0]  out_z;
        logic [SEG_W-1:0]         segment;
        status_t                  status;
    } rsp_word_t;

    typedef struct packed {
        logic [TIME_W-1:0]        key_time;
        logic signed [VAL_W-1:0]  x;
        logic signed [VAL_W-1:0]  y;
        logic signed [VAL_W-1:0]  z;
    } key_row_t;

endpackage

### rtl/kli_ram.sv
module kli_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/kli_div.sv
module kli_div (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [kli_pkg::TIME_W-1:0]       num,
    input  logic [kli_pkg::TIME_W-1:0]       den,
    output logic                             done,
    output logic [kli_pkg::FRAC_BITS-1:0]    quotient
);

    // restoring division of (num << FRAC_BITS) by den, one bit a cycle; num < den
    logic [kli_pkg::TIME_W-1:0]    rem_reg, rem_next;
    logic [kli_pkg::TIME_W-1:0]    den_reg, den_next;
    logic [kli_pkg::FRAC_BITS-1:0] quo_reg, quo_next;
    logic [kli_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [kli_pkg::TIME_W:0]      shifted;
    logic                          fits;
    logic                          last_step;

    assign shifted   = {rem_reg, 1'b0};
    assign fits      = shifted >= {1'b0, den_reg};
    assign last_step = cnt_reg == kli_pkg::DIV_CNT_W'(kli_pkg::FRAC_BITS - 1);

    always_comb
    begin
        rem_next  = rem_reg;
        den_next  = den_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = num;
            den_next  = den;
            quo_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_next = kli_pkg::TIME_W'(shifted - {1'b0, den_reg});
            end
            else
            begin
                rem_next = kli_pkg::TIME_W'(shifted);
            end
            quo_next = {quo_reg[kli_pkg::FRAC_BITS-2:0], fits};
            cnt_next = cnt_reg + kli_pkg::DIV_CNT_W'(1);
            if (last_step)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

### rtl/keyframe_linear_interpolator_core.sv
// channel   signals                         direction  word
// request   req_valid req_stall req_word    in         kli_pkg::req_word_t
// response  rsp_valid rsp_stall rsp_word    out        kli_pkg::rsp_word_t
// config    cfg_we cfg_wdata                in         key_count, 5 bits
//
// a keyframe write never raises req_stall; a query holds req_stall high until
// its result sits in the response register; with more than one key its wait
// is set by the key scan (one key a cycle through the table's read port), the
// 16-step divider and one shared multiplier used per component
// reset clears control state and key_count to 1; the key table is not cleared
// a stalled response holds its word; the next request is taken meanwhile
module keyframe_linear_interpolator_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  kli_pkg::req_word_t            req_word,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output kli_pkg::rsp_word_t            rsp_word,
    input  logic                          cfg_we,
    input  logic [kli_pkg::COUNT_W-1:0]   cfg_wdata
);

    localparam int KW = kli_pkg::KEY_IDX_W;

    kli_pkg::fsm_t                      state_reg, state_next;
    logic [kli_pkg::COUNT_W-1:0]        key_count_reg;
    logic [KW-1:0]                      cmp_idx_reg, cmp_idx_next;
    logic [KW-1:0]                      seg_reg, seg_next;
    logic                               single_reg, single_next;
    logic [kli_pkg::TIME_W-1:0]         query_reg, query_next;
    kli_pkg::key_row_t                  a_row_reg, a_row_next;
    kli_pkg::key_row_t                  b_row_reg, b_row_next;
    logic [1:0]                         comp_reg, comp_next;
    logic signed [kli_pkg::DIFF_W-1:0]  diff_reg, diff_next;
    logic signed [kli_pkg::PROD_W-1:0]  prod_reg, prod_next;
    logic signed [kli_pkg::VAL_W-1:0]   res_x_reg, res_x_next;
    logic signed [kli_pkg::VAL_W-1:0]   res_y_reg, res_y_next;
    logic signed [kli_pkg::VAL_W-1:0]   res_z_reg, res_z_next;
    kli_pkg::status_t                   status_reg, status_next;
    logic                               rsp_valid_reg, rsp_valid_next;
    kli_pkg::rsp_word_t                 rsp_word_reg, rsp_word_next;

    logic [KW-1:0]                      last_idx;
    logic [KW-1:0]                      rd_addr;
    logic                               ram_we;
    logic                               slot_ok;
    logic [$bits(kli_pkg::key_row_t)-1:0] ram_rdata;
    kli_pkg::key_row_t                  wr_row;
    kli_pkg::key_row_t                  rd_row;
    logic                               div_start;
    logic [kli_pkg::TIME_W-1:0]         div_num, div_den;
    logic                               div_done;
    logic [kli_pkg::FRAC_BITS-1:0]      div_quo;
    logic signed [kli_pkg::VAL_W-1:0]   a_comp, b_comp;
    logic signed [kli_pkg::VAL_W-1:0]   lerp_sum;

    // last key in use, key_count of zero acts as one, above the table as full
    always_comb
    begin
        if (key_count_reg == '0)
        begin
            last_idx = '0;
        end
        else if (32'(key_count_reg) > 32'(kli_pkg::MAX_KEYS))
        begin
            last_idx = KW'(kli_pkg::MAX_KEYS - 1);
        end
        else
        begin
            last_idx = KW'(key_count_reg - kli_pkg::COUNT_W'(1));
        end
    end

    assign slot_ok = 32'(req_word.key_index) < 32'(kli_pkg::MAX_KEYS);
    assign wr_row  = '{key_time: req_word.key_time, x: req_word.value_x,
                       y: req_word.value_y, z: req_word.value_z};
    assign rd_row  = kli_pkg::key_row_t'(ram_rdata);

    // one row holds a key's time and all three components
    kli_ram #(
        .WIDTH ($bits(kli_pkg::key_row_t)),
        .DEPTH (kli_pkg::MAX_KEYS)
    ) u_key_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (KW'(req_word.key_index)),
        .wdata (wr_row),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    // segment span: t0 <= q < t1 so the divisor is never zero
    assign div_num = query_reg - rd_row.key_time;
    assign div_den = b_row_reg.key_time - rd_row.key_time;

    kli_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .num      (div_num),
        .den      (div_den),
        .done     (div_done),
        .quotient (div_quo)
    );

    // component picked for the shared subtract, multiply and add
    always_comb
    begin
        case (comp_reg)
            2'd0:
            begin
                a_comp = a_row_reg.x;
                b_comp = b_row_reg.x;
            end
            2'd1:
            begin
                a_comp = a_row_reg.y;
                b_comp = b_row_reg.y;
            end
            default:
            begin
                a_comp = a_row_reg.z;
                b_comp = b_row_reg.z;
            end
        endcase
    end

    // arithmetic shift gives the floor of the scaled step for either sign
    assign lerp_sum = a_comp + kli_pkg::VAL_W'(prod_reg >>> kli_pkg::FRAC_BITS);

    always_comb
    begin
        state_next     = state_reg;
        cmp_idx_next   = cmp_idx_reg;
        seg_next       = seg_reg;
        single_next    = single_reg;
        query_next     = query_reg;
        a_row_next     = a_row_reg;
        b_row_next     = b_row_reg;
        comp_next      = comp_reg;
        diff_next      = diff_reg;
        prod_next      = prod_reg;
        res_x_next     = res_x_reg;
        res_y_next     = res_y_reg;
        res_z_next     = res_z_reg;
        status_next    = status_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_word_next  = rsp_word_reg;
        rd_addr        = '0;
        ram_we         = 1'b0;
        div_start      = 1'b0;

        unique case (state_reg)
            kli_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    if (req_word.opcode == kli_pkg::OP_WRITE)
                    begin
                        ram_we = slot_ok;
                    end
                    else
                    begin
                        query_next = req_word.query_time;
                        if (last_idx == '0)
                        begin
                            single_next = 1'b1;
                            seg_next    = '0;
                            rd_addr     = '0;
                            state_next  = kli_pkg::S_LOAD_A;
                        end
                        else
                        begin
                            // start the scan at the end time of the first segment
                            single_next  = 1'b0;
                            cmp_idx_next = KW'(1);
                            rd_addr      = KW'(1);
                            state_next   = kli_pkg::S_SEARCH;
                        end
                    end
                end
            end

            kli_pkg::S_SEARCH:
            begin
                // read data is the row at cmp_idx_reg
                if (query_reg < rd_row.key_time)
                begin
                    b_row_next = rd_row;
                    seg_next   = cmp_idx_reg - KW'(1);
                    rd_addr    = cmp_idx_reg - KW'(1);
                    state_next = kli_pkg::S_LOAD_A;
                end
                else if (cmp_idx_reg == last_idx)
                begin
                    // past the last key: that key is already on the read port
                    res_x_next  = rd_row.x;
                    res_y_next  = rd_row.y;
                    res_z_next  = rd_row.z;
                    seg_next    = cmp_idx_reg;
                    status_next = kli_pkg::ST_PAST;
                    state_next  = kli_pkg::S_OUT;
                end
                else
                begin
                    cmp_idx_next = cmp_idx_reg + KW'(1);
                    rd_addr      = cmp_idx_reg + KW'(1);
                end
            end

            kli_pkg::S_LOAD_A:
            begin
                a_row_next = rd_row;
                if (single_reg || (query_reg < rd_row.key_time))
                begin
                    res_x_next  = rd_row.x;
                    res_y_next  = rd_row.y;
                    res_z_next  = rd_row.z;
                    status_next = single_reg ? kli_pkg::ST_SINGLE : kli_pkg::ST_CLAMPED;
                    state_next  = kli_pkg::S_OUT;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = kli_pkg::S_DIV;
                end
            end

            kli_pkg::S_DIV:
            begin
                if (div_done)
                begin
                    comp_next  = 2'd0;
                    state_next = kli_pkg::S_DIFF;
                end
            end

            kli_pkg::S_DIFF:
            begin
                diff_next  = kli_pkg::DIFF_W'(b_comp) - kli_pkg::DIFF_W'(a_comp);
                state_next = kli_pkg::S_MUL;
            end

            kli_pkg::S_MUL:
            begin
                prod_next  = diff_reg * $signed({1'b0, div_quo});
                state_next = kli_pkg::S_ADD;
            end

            kli_pkg::S_ADD:
            begin
                case (comp_reg)
                    2'd0:    res_x_next = lerp_sum;
                    2'd1:    res_y_next = lerp_sum;
                    default: res_z_next = lerp_sum;
                endcase
                if (comp_reg == 2'd2)
                begin
                    status_next = kli_pkg::ST_OK;
                    state_next  = kli_pkg::S_OUT;
                end
                else
                begin
                    comp_next  = comp_reg + 2'd1;
                    state_next = kli_pkg::S_DIFF;
                end
            end

            kli_pkg::S_OUT:
            begin
                // wait for the response register to be free
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_word_next  = '{out_x: res_x_reg, out_y: res_y_reg,
                                       out_z: res_z_reg,
                                       segment: kli_pkg::SEG_W'(seg_reg),
                                       status: status_reg};
                    state_next     = kli_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = kli_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= kli_pkg::S_IDLE;
            key_count_reg <= kli_pkg::COUNT_W'(1);
            rsp_valid_reg <= 1'b0;
            single_reg    <= 1'b0;
            cmp_idx_reg   <= '0;
            comp_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            single_reg    <= single_next;
            cmp_idx_reg   <= cmp_idx_next;
            comp_reg      <= comp_next;
            if (cfg_we)
            begin
                key_count_reg <= cfg_wdata;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        seg_reg      <= seg_next;
        query_reg    <= query_next;
        a_row_reg    <= a_row_next;
        b_row_reg    <= b_row_next;
        diff_reg     <= diff_next;
        prod_reg     <= prod_next;
        res_x_reg    <= res_x_next;
        res_y_reg    <= res_y_next;
        res_z_reg    <= res_z_next;
        status_reg   <= status_next;
        rsp_word_reg <= rsp_word_next;
    end

    assign req_stall = state_reg != kli_pkg::S_IDLE;
    assign rsp_valid = rsp_valid_reg;
    assign rsp_word  = rsp_word_reg;

    // a finished query reaches the response register once it is free
    a_out_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == kli_pkg::S_OUT) && !(rsp_valid_reg && rsp_stall)
        |=> rsp_valid_reg && (state_reg == kli_pkg::S_IDLE))
        else $error("finished query not moved to response register");

    // the divider only finishes while the sequencer waits for it
    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == kli_pkg::S_DIV))
        else $error("divider finished outside its wait state");

    // the scan never reads beyond the keys in use
    a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == kli_pkg::S_SEARCH)
        |-> (cmp_idx_reg != '0) && (cmp_idx_reg <= last_idx))
        else $error("key scan out of range");

    // a single key result always names key zero
    a_single_seg: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && (rsp_word_reg.status == kli_pkg::ST_SINGLE)
        |-> (rsp_word_reg.segment == '0))
        else $error("single key result with nonzero segment");

endmodule
